[hw/rtl/odd_only_prime_sieve_counter_unit_macros.svh]
// assertion helpers for the sieve counter checker
`ifndef ODD_ONLY_PRIME_SIEVE_COUNTER_UNIT_MACROS_SVH
`define ODD_ONLY_PRIME_SIEVE_COUNTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OPSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("opsc checker: property failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define OPSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("opsc checker: property failed");

`endif

[hw/rtl/opsc_pkg.sv]
`default_nettype none

package opsc_pkg;

  localparam int MAX_LIMIT = 1048576;
  localparam int WORD_BITS = 64;

  localparam int LIMIT_W   = 21;
  localparam int COUNT_W   = 17;

  localparam int ODD_WORDS = MAX_LIMIT / 2 / WORD_BITS + 1;
  localparam int ADDR_W    = $clog2(ODD_WORDS);
  localparam int NW_W      = $clog2(ODD_WORDS + 1);
  localparam int BIT_IDX_W = $clog2(WORD_BITS);
  localparam int PC_W      = $clog2(WORD_BITS + 1);
  localparam int LIM_W     = $clog2(MAX_LIMIT + 1);
  localparam int IN_CMP_W  = (LIMIT_W > LIM_W) ? LIMIT_W : LIM_W;
  localparam int NBITS_W   = $clog2(MAX_LIMIT / 2);
  localparam int NBX_W     = NBITS_W + 1;
  localparam int J_W       = NBITS_W + 1;
  // candidates stop just above the square root of the limit
  localparam int P_W       = ($clog2(MAX_LIMIT) + 1) / 2 + 1;
  localparam int SQ_W      = 2 * P_W;
  localparam int CMP_W     = (SQ_W > LIM_W) ? SQ_W : LIM_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCAN_CHK,
    ST_SCAN_TST,
    ST_CLR_RD,
    ST_CLR_WR,
    ST_CNT_RD,
    ST_CNT_ACC,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_CLR,
    RD_CNT
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    fill_we;
    logic    p_adv;
    logic    j_load;
    logic    clr_we;
    logic    cnt_init;
    logic    cnt_acc;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic lim_low;
    logic words_done;
    logic scan_done;
    logic cand_set;
    logic clr_last;
  } stat_t;

endpackage

`default_nettype wire

[hw/rtl/opsc_datapath.sv]
`default_nettype none

module opsc_datapath (
  input  wire logic                         clk,
  input  wire opsc_pkg::cmd_t               cmd,
  input  wire logic [opsc_pkg::LIMIT_W-1:0] in_limit,
  output opsc_pkg::stat_t                   stat,
  output logic [opsc_pkg::COUNT_W-1:0]      prime_count
);

  localparam int WB   = opsc_pkg::WORD_BITS;
  localparam int BI_W = opsc_pkg::BIT_IDX_W;

  function automatic logic [opsc_pkg::PC_W-1:0] popcount(input logic [WB-1:0] v);
    logic [opsc_pkg::PC_W-1:0] acc [WB];
    for (int k = 0; k < WB; k++) acc[k] = opsc_pkg::PC_W'(v[k]);
    // pairwise adder tree, one level per pass
    for (int lv = 1; lv < WB; lv = lv * 2) begin
      for (int k = 0; k < WB; k = k + 2 * lv) acc[k] = acc[k] + acc[k + lv];
    end
    return acc[0];
  endfunction

  logic [WB-1:0] bitmap_mem [opsc_pkg::ODD_WORDS];

  logic [opsc_pkg::LIM_W-1:0]   lim_r;
  logic [opsc_pkg::NBITS_W-1:0] nbits_r;
  logic [opsc_pkg::NW_W-1:0]    nwords_r;
  logic [opsc_pkg::NW_W-1:0]    w_r;
  logic [opsc_pkg::P_W-1:0]     p_r;
  logic [opsc_pkg::SQ_W-1:0]    p2_r;
  logic [opsc_pkg::J_W-1:0]     j_r;
  logic [opsc_pkg::COUNT_W-1:0] count_r;
  logic [WB-1:0]                rd_data_r;

  logic [opsc_pkg::LIM_W-1:0]   lim_sat;
  logic [opsc_pkg::NBITS_W-1:0] nbits_in;
  logic [opsc_pkg::NBX_W-1:0]   nw_raw;
  logic [opsc_pkg::NW_W-1:0]    nwords_in;
  logic [opsc_pkg::P_W-1:0]     cand_idx;
  logic [opsc_pkg::J_W-1:0]     j_sum;
  logic [opsc_pkg::NBITS_W-1:0] first_bit;
  logic [opsc_pkg::NBITS_W-1:0] rem_bits;
  logic [WB-1:0]                keep_mask;
  logic [opsc_pkg::ADDR_W-1:0]  rd_addr;
  logic [opsc_pkg::ADDR_W-1:0]  wr_addr;
  logic [WB-1:0]                wr_data;
  logic                         wr_en;

  // request decode
  always_comb begin
    if (opsc_pkg::IN_CMP_W'(in_limit) > opsc_pkg::IN_CMP_W'(opsc_pkg::MAX_LIMIT)) begin
      lim_sat = opsc_pkg::LIM_W'(opsc_pkg::MAX_LIMIT);
    end else begin
      lim_sat = opsc_pkg::LIM_W'(in_limit);
    end
    nbits_in = opsc_pkg::NBITS_W'((lim_sat - opsc_pkg::LIM_W'(2)) >> 1);
    nw_raw   = ({1'b0, nbits_in} + opsc_pkg::NBX_W'(WB - 1)) >> BI_W;
    if (nw_raw > opsc_pkg::NBX_W'(opsc_pkg::ODD_WORDS)) begin
      nwords_in = opsc_pkg::NW_W'(opsc_pkg::ODD_WORDS);
    end else begin
      nwords_in = opsc_pkg::NW_W'(nw_raw);
    end
  end

  assign cand_idx  = (p_r - opsc_pkg::P_W'(3)) >> 1;
  assign j_sum     = j_r + opsc_pkg::J_W'(p_r);
  assign first_bit = opsc_pkg::NBITS_W'({w_r, BI_W'(0)});
  assign rem_bits  = nbits_r - first_bit;

  // last word of the run holds bits past the limit
  always_comb begin
    if ({1'b0, rem_bits} < opsc_pkg::NBX_W'(WB)) begin
      keep_mask = ~({WB{1'b1}} << rem_bits);
    end else begin
      keep_mask = '1;
    end
  end

  always_comb begin
    stat.lim_low    = lim_sat <= opsc_pkg::LIM_W'(2);
    stat.words_done = w_r == nwords_r;
    stat.scan_done  = (nbits_r == '0) ||
                      (opsc_pkg::CMP_W'(p2_r) >= opsc_pkg::CMP_W'(lim_r));
    stat.cand_set   = rd_data_r[BI_W'(cand_idx)];
    stat.clr_last   = j_sum >= opsc_pkg::J_W'(nbits_r);
  end

  always_comb begin
    unique case (cmd.rd_sel)
      opsc_pkg::RD_SCAN: rd_addr = opsc_pkg::ADDR_W'(cand_idx >> BI_W);
      opsc_pkg::RD_CLR:  rd_addr = opsc_pkg::ADDR_W'(j_r >> BI_W);
      opsc_pkg::RD_CNT:  rd_addr = opsc_pkg::ADDR_W'(w_r);
      default:           rd_addr = opsc_pkg::ADDR_W'(w_r);
    endcase
  end

  // single write port: fill with ones or clear one multiple
  always_comb begin
    wr_en = cmd.fill_we | cmd.clr_we;
    if (cmd.clr_we) begin
      wr_addr = opsc_pkg::ADDR_W'(j_r >> BI_W);
      wr_data = rd_data_r & ~(WB'(1) << BI_W'(j_r));
    end else begin
      wr_addr = opsc_pkg::ADDR_W'(w_r);
      wr_data = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= bitmap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lim_r    <= lim_sat;
      nbits_r  <= nbits_in;
      nwords_r <= nwords_in;
      w_r      <= '0;
      p_r      <= opsc_pkg::P_W'(3);
      p2_r     <= opsc_pkg::SQ_W'(9);
      count_r  <= '0;
    end
    if (cmd.fill_we) begin
      w_r <= w_r + opsc_pkg::NW_W'(1);
    end
    // (p+2)^2 = p^2 + 4p + 4
    if (cmd.p_adv) begin
      p_r  <= p_r + opsc_pkg::P_W'(2);
      p2_r <= p2_r + (opsc_pkg::SQ_W'(p_r) << 2) + opsc_pkg::SQ_W'(4);
    end
    if (cmd.j_load) begin
      j_r <= opsc_pkg::J_W'((p2_r - opsc_pkg::SQ_W'(3)) >> 1);
    end
    if (cmd.clr_we) begin
      j_r <= j_sum;
    end
    // the prime 2 is counted up front
    if (cmd.cnt_init) begin
      count_r <= opsc_pkg::COUNT_W'(1);
      w_r     <= '0;
    end
    if (cmd.cnt_acc) begin
      count_r <= count_r + opsc_pkg::COUNT_W'(popcount(rd_data_r & keep_mask));
      w_r     <= w_r + opsc_pkg::NW_W'(1);
    end
  end

  assign prime_count = count_r;

endmodule

`default_nettype wire

[hw/rtl/opsc_ctrl.sv]
`default_nettype none

module opsc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire opsc_pkg::stat_t stat,
  output opsc_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 done
);

  opsc_pkg::state_t state_r;
  opsc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= opsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    unique case (state_r)
      opsc_pkg::ST_IDLE: begin
        if (!start) state_nxt = opsc_pkg::ST_IDLE;
        else if (stat.lim_low) state_nxt = opsc_pkg::ST_DONE;
        else state_nxt = opsc_pkg::ST_FILL;
      end
      opsc_pkg::ST_FILL:
        state_nxt = stat.words_done ? opsc_pkg::ST_SCAN_CHK : opsc_pkg::ST_FILL;
      opsc_pkg::ST_SCAN_CHK:
        state_nxt = stat.scan_done ? opsc_pkg::ST_CNT_RD : opsc_pkg::ST_SCAN_TST;
      opsc_pkg::ST_SCAN_TST:
        state_nxt = stat.cand_set ? opsc_pkg::ST_CLR_RD : opsc_pkg::ST_SCAN_CHK;
      opsc_pkg::ST_CLR_RD:
        state_nxt = opsc_pkg::ST_CLR_WR;
      opsc_pkg::ST_CLR_WR:
        state_nxt = stat.clr_last ? opsc_pkg::ST_SCAN_CHK : opsc_pkg::ST_CLR_RD;
      opsc_pkg::ST_CNT_RD:
        state_nxt = stat.words_done ? opsc_pkg::ST_DONE : opsc_pkg::ST_CNT_ACC;
      opsc_pkg::ST_CNT_ACC:
        state_nxt = opsc_pkg::ST_CNT_RD;
      opsc_pkg::ST_DONE:
        state_nxt = opsc_pkg::ST_IDLE;
      default:
        state_nxt = opsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = opsc_pkg::RD_CNT;
    busy     = 1'b1;
    done     = 1'b0;
    unique case (state_r)
      opsc_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      opsc_pkg::ST_FILL: begin
        cmd.fill_we = !stat.words_done;
      end
      opsc_pkg::ST_SCAN_CHK: begin
        cmd.rd_sel   = opsc_pkg::RD_SCAN;
        cmd.cnt_init = stat.scan_done;
      end
      opsc_pkg::ST_SCAN_TST: begin
        // composites are skipped, primes start a marking pass
        cmd.j_load = stat.cand_set;
        cmd.p_adv  = !stat.cand_set;
      end
      opsc_pkg::ST_CLR_RD: begin
        cmd.rd_sel = opsc_pkg::RD_CLR;
      end
      opsc_pkg::ST_CLR_WR: begin
        cmd.clr_we = 1'b1;
        cmd.p_adv  = stat.clr_last;
      end
      opsc_pkg::ST_CNT_RD: begin
        cmd.rd_sel = opsc_pkg::RD_CNT;
      end
      opsc_pkg::ST_CNT_ACC: begin
        cmd.cnt_acc = 1'b1;
      end
      opsc_pkg::ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/odd_only_prime_sieve_counter_unit.sv]
`default_nettype none

// Counts the primes strictly below in_limit (limits above 1048576 saturate to
// it). Pulse start while busy is low; the request is taken on that edge and
// busy stays high until the answer has been shown. out_prime_count is valid for
// exactly one cycle with out_valid high and is not held: the receiver must take
// it on that cycle. A limit of 2 or less answers in the cycle after the
// transfer. Otherwise the run fills each bitmap word with ones, tests each
// sieve candidate up to the square root of the limit, clears the multiples of
// each prime bit by bit and counts each word, all on the single bitmap memory
// with one read and one write port.
module odd_only_prime_sieve_counter_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [opsc_pkg::LIMIT_W-1:0] in_limit,
  output logic                              out_valid,
  output logic [opsc_pkg::COUNT_W-1:0]      out_prime_count
);

  opsc_pkg::cmd_t  cmd;
  opsc_pkg::stat_t stat;

  opsc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  opsc_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .in_limit    (in_limit),
    .stat        (stat),
    .prime_count (out_prime_count)
  );

endmodule

`default_nettype wire

[hw/rtl/opsc_checker.sv]
`default_nettype none

`include "odd_only_prime_sieve_counter_unit_macros.svh"

module opsc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [opsc_pkg::LIMIT_W-1:0] in_limit,
  input wire logic                         out_valid,
  input wire logic [opsc_pkg::COUNT_W-1:0] out_prime_count
);

  // a transfer always starts a run
  `OPSC_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `OPSC_ASSERT_NXT(a_strobe_single, out_valid, !out_valid)
  // the block only frees up right after showing a result
  `OPSC_ASSERT_IMP(a_busy_release, $fell(busy), $past(out_valid))
  `OPSC_ASSERT_NXT(a_small_limit, start && !busy && in_limit <= 2, out_valid && out_prime_count == 0)

endmodule

bind odd_only_prime_sieve_counter_unit opsc_checker u_opsc_checker (.*);

`default_nettype wire

[tb/odd_only_prime_sieve_counter_unit_tb.sv]
module odd_only_prime_sieve_counter_unit_tb;

  localparam int ODD_SPAN  = opsc_pkg::MAX_LIMIT / 2;
  localparam int N_DIRECTED = 21;
  localparam int N_RANDOM_PER_PHASE = 27;
  localparam int SETTLE_CYCLES = 50;
  // a count of -1 in the table means the row is checked against the sieve
  localparam int FROM_SIEVE = -1;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [opsc_pkg::LIMIT_W-1:0]   in_limit;
  logic                           out_valid;
  logic [opsc_pkg::COUNT_W-1:0]   out_prime_count;

  logic [opsc_pkg::LIMIT_W-1:0]   pending_limit[$];
  logic [opsc_pkg::COUNT_W-1:0]   pending_count[$];
  bit                             odd_alive [0:ODD_SPAN];
  int                             idle_pct;
  int                             fail_count;

  int dir_limit [N_DIRECTED] = '{
    0, 1, 2, 3, 4, 5, 7, 9, 10, 25, 26, 49,
    100, 128, 130, 131, 132, 1000, 1024, 2097151, 0
  };
  int dir_count [N_DIRECTED] = '{
    0, 0, 0, 1, 2, 2, 3, 4, 4, 9, 9, 15,
    25, FROM_SIEVE, FROM_SIEVE, FROM_SIEVE, FROM_SIEVE, 168, 172, 82025, 0
  };

  odd_only_prime_sieve_counter_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_limit        (in_limit),
    .out_valid       (out_valid),
    .out_prime_count (out_prime_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(64'd240_000_000);
    $display("odd_only_prime_sieve_counter_unit regression: fail");
    $finish;
  end

  // odd-only sieve: entry i stands for the odd value 2*i+3
  function automatic logic [opsc_pkg::COUNT_W-1:0] primes_below(
    input logic [opsc_pkg::LIMIT_W-1:0] lim_in
  );
    int lim;
    int span;
    int p;
    int j;
    int total;
    lim = int'(lim_in);
    if (lim > opsc_pkg::MAX_LIMIT) lim = opsc_pkg::MAX_LIMIT;
    if (lim <= 2) return '0;
    span = (lim - 2) / 2;
    for (int i = 0; i < span; i++) odd_alive[i] = 1'b1;
    for (int i = 0; i < span; i++) begin
      p = 2 * i + 3;
      if (p * p >= lim) break;
      if (odd_alive[i]) begin
        for (j = (p * p - 3) / 2; j < span; j += p) odd_alive[j] = 1'b0;
      end
    end
    total = 1;
    for (int i = 0; i < span; i++) total += int'(odd_alive[i]);
    return total[opsc_pkg::COUNT_W-1:0];
  endfunction

  // drives one request and records its answer once the transfer happens
  task automatic send_limit(input logic [opsc_pkg::LIMIT_W-1:0] lim, input int typed_count);
    logic [opsc_pkg::COUNT_W-1:0] want;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start    <= 1'b1;
    in_limit <= lim;
    do @(posedge clk); while (busy);
    if (typed_count == FROM_SIEVE) want = primes_below(lim);
    else want = typed_count[opsc_pkg::COUNT_W-1:0];
    pending_limit.push_back(lim);
    pending_count.push_back(want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_count.size() == 0) begin
        $display("%0t: unexpected prime count: expected none, actual %0d",
                 $time, out_prime_count);
        fail_count <= fail_count + 1;
      end else begin
        if (out_prime_count !== pending_count[0]) begin
          $display("%0t: prime count for limit %0d: expected %0d, actual %0d",
                   $time, pending_limit[0], pending_count[0], out_prime_count);
          fail_count <= fail_count + 1;
        end
        void'(pending_limit.pop_front());
        void'(pending_count.pop_front());
      end
    end
  end

  initial begin
    int phase_idle [3];
    int r;
    logic [opsc_pkg::LIMIT_W-1:0] lim;
    phase_idle = '{0, 63, 12};
    fail_count = 0;
    idle_pct   = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_limit   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      send_limit(opsc_pkg::LIMIT_W'(dir_limit[k]), dir_count[k]);
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_idle[ph];
      for (int k = 0; k < N_RANDOM_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        // mostly cheap runs; a few larger ones keep the upper bits moving
        if (r < 10) lim = opsc_pkg::LIMIT_W'($urandom_range(0, 12));
        else if (r < 80) lim = opsc_pkg::LIMIT_W'($urandom_range(13, 2048));
        else if (r < 95) lim = opsc_pkg::LIMIT_W'($urandom_range(2049, 16384));
        else lim = opsc_pkg::LIMIT_W'($urandom_range(16385, 65536));
        send_limit(lim, FROM_SIEVE);
      end
    end
    start <= 1'b0;

    while (pending_count.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("odd_only_prime_sieve_counter_unit regression: pass");
    end else begin
      $display("odd_only_prime_sieve_counter_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/opsc_pkg.sv
hw/rtl/opsc_datapath.sv
hw/rtl/opsc_ctrl.sv
hw/rtl/odd_only_prime_sieve_counter_unit.sv
hw/rtl/opsc_checker.sv
tb/odd_only_prime_sieve_counter_unit_tb.sv
